// ===== design/cau_pkg.sv =====
// Shared types, widths and codes for the complex arithmetic unit.
// No dependencies; imported by the top level and its port checker.
`default_nettype none
package cau_pkg;

   localparam int DATA_W    = 32;               // one operand or result part
   localparam int FRAC_BITS = 16;               // fraction bits of the fixed-point format
   localparam int PROD_W    = 2 * DATA_W;       // exact product
   localparam int SUM_W     = PROD_W + 1;       // exact sum of two products
   localparam int QUOT_W    = DATA_W + 1;       // quotient bits kept before clamping
   localparam int ROOT_W    = DATA_W;           // floor square root of a 64-bit value
   localparam int SQREM_W   = ROOT_W + 4;       // square root partial remainder
   localparam int NUM_W     = PROD_W + FRAC_BITS; // scaled dividend
   localparam int HI_W      = NUM_W - QUOT_W;   // dividend bits above the quotient window
   localparam int REQ_DATA_W = 4 * DATA_W;
   localparam int RSP_DATA_W = 2 * DATA_W;
   localparam int OP_W       = 3;
   localparam int RSP_USER_W = 3;

   // Result flags in rsp_tuser
   localparam int FLAG_EQUAL = 0;
   localparam int FLAG_SAT   = 1;
   localparam int FLAG_DZ    = 2;

   typedef enum logic [OP_W-1:0] {
      OP_ADD   = 3'd0,
      OP_SUB   = 3'd1,
      OP_MUL   = 3'd2,
      OP_DIV   = 3'd3,
      OP_MAG   = 3'd4,
      OP_CONJ  = 3'd5,
      OP_EQUAL = 3'd6
   } op_type;

   // One slot of the divide / square root pipeline
   typedef struct packed {
      op_type                    op;
      logic                      neg_re;
      logic                      neg_im;
      logic                      ovf_re;
      logic                      ovf_im;
      logic                      dz;
      logic [PROD_W-1:0]         den;
      logic [PROD_W-1:0]         rem_re;
      logic [PROD_W-1:0]         rem_im;
      logic [QUOT_W-1:0]         lo_re;
      logic [QUOT_W-1:0]         lo_im;
      logic [QUOT_W-1:0]         q_re;
      logic [QUOT_W-1:0]         q_im;
      logic [PROD_W-1:0]         sq_n;
      logic [SQREM_W-1:0]        sq_rem;
      logic [ROOT_W-1:0]         sq_root;
      logic [DATA_W-1:0]         early_re;
      logic [DATA_W-1:0]         early_im;
      logic                      early_eq;
      logic                      early_sat;
   } it_type;

endpackage
`default_nettype wire

// ===== design/complex_arithmetic_unit.sv =====
// Complex arithmetic unit top level: fully pipelined add/sub/mul/div/magnitude/conj/equal.
// Depends on cau_pkg.
//
//   channel | direction | tdata (low bit up)                     | tuser (low bit up)
//   req_    | in        | a_re, a_im, b_re, b_im (32 b each)     | operation (3 b)
//   rsp_    | out       | result_re, result_im (32 b each)       | is_equal, saturated,
//           |           |                                        |   divide_by_zero
//
// One item enters per cycle while no result is held at the output; every operation passes
// through the 33 restoring-divide stages (the square root runs in the first 32 of them).
// Reset (synchronous) clears every valid bit; payload registers are not reset.
// A stalled result holds the output register and freezes the whole pipeline, so
// req_tready is low exactly while a result waits and rsp_tready is low.
`default_nettype none
module complex_arithmetic_unit (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_tvalid,
   output logic                            req_tready,
   input  wire  [cau_pkg::REQ_DATA_W-1:0]  req_tdata,  // a_re, a_im, b_re, b_im
   input  wire  [cau_pkg::OP_W-1:0]        req_tuser,  // operation
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   output logic [cau_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // result_re, result_im
   output logic [cau_pkg::RSP_USER_W-1:0]  rsp_tuser   // is_equal, saturated, divide_by_zero
);
   import cau_pkg::*;

   localparam logic [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] MIN_NEG = {1'b1, {(DATA_W-1){1'b0}}};

   // Clamp a 33-bit sum; returns {sat, value}
   function automatic logic [DATA_W:0] clamp33(input logic [DATA_W:0] s);
      logic [DATA_W:0] r;
      if (s[DATA_W] != s[DATA_W-1]) begin
         r = {1'b1, (s[DATA_W] ? MIN_NEG : MAX_POS)};
      end else begin
         r = {1'b0, s[DATA_W-1:0]};
      end
      return r;
   endfunction

   // Clamp a wide signed value; returns {sat, value}
   function automatic logic [DATA_W:0] clamp_wide(input logic [SUM_W-1:0] s);
      logic [DATA_W:0] r;
      if (s[SUM_W-1:DATA_W-1] != {(SUM_W-DATA_W+1){s[SUM_W-1]}}) begin
         r = {1'b1, (s[SUM_W-1] ? MIN_NEG : MAX_POS)};
      end else begin
         r = {1'b0, s[DATA_W-1:0]};
      end
      return r;
   endfunction

   // Clamp a sign/magnitude quotient; returns {sat, value}
   function automatic logic [DATA_W:0] clamp_sm(input logic neg, input logic ovf,
                                                input logic [QUOT_W-1:0] q);
      logic [DATA_W:0] r;
      if (!neg) begin
         if (ovf || q[QUOT_W-1:DATA_W-1] != '0) r = {1'b1, MAX_POS};
         else r = {1'b0, q[DATA_W-1:0]};
      end else begin
         if (ovf || q[QUOT_W-1:DATA_W] != '0 || (q[DATA_W-1] && q[DATA_W-2:0] != '0)) begin
            r = {1'b1, MIN_NEG};
         end else begin
            r = {1'b0, DATA_W'(-q[DATA_W-1:0])};
         end
      end
      return r;
   endfunction

   logic en;

   // ---------------- stage 1: input register
   logic                     s1_vld_ff;
   op_type                   s1_op_ff;
   logic signed [DATA_W-1:0] s1_ar_ff, s1_ai_ff, s1_br_ff, s1_bi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_tvalid;
      end
      if (en) begin
         s1_op_ff <= op_type'(req_tuser);
         s1_ar_ff <= req_tdata[DATA_W-1:0];
         s1_ai_ff <= req_tdata[2*DATA_W-1:DATA_W];
         s1_br_ff <= req_tdata[3*DATA_W-1:2*DATA_W];
         s1_bi_ff <= req_tdata[4*DATA_W-1:3*DATA_W];
      end
   end

   // ---------------- stage 2: six products, plus the one-step operations
   logic                     s2_vld_ff;
   op_type                   s2_op_ff;
   logic signed [PROD_W-1:0] s2_p_ff [0:5];
   logic [DATA_W-1:0]        s2_re_ff, s2_im_ff, s2_re_in, s2_im_in;
   logic                     s2_eq_ff, s2_sat_ff, s2_eq_in, s2_sat_in;
   logic signed [DATA_W-1:0] sq_x, sq_y;
   logic [DATA_W:0]          c_re, c_im;

   always_comb begin
      sq_x = (s1_op_ff == OP_MAG) ? s1_ar_ff : s1_br_ff;
      sq_y = (s1_op_ff == OP_MAG) ? s1_ai_ff : s1_bi_ff;
      c_re = '0;
      c_im = '0;
      s2_eq_in = 1'b0;
      case (s1_op_ff)
         OP_ADD: begin
            c_re = clamp33({s1_ar_ff[DATA_W-1], s1_ar_ff} + {s1_br_ff[DATA_W-1], s1_br_ff});
            c_im = clamp33({s1_ai_ff[DATA_W-1], s1_ai_ff} + {s1_bi_ff[DATA_W-1], s1_bi_ff});
         end
         OP_SUB: begin
            c_re = clamp33({s1_ar_ff[DATA_W-1], s1_ar_ff} - {s1_br_ff[DATA_W-1], s1_br_ff});
            c_im = clamp33({s1_ai_ff[DATA_W-1], s1_ai_ff} - {s1_bi_ff[DATA_W-1], s1_bi_ff});
         end
         OP_CONJ: begin
            c_re = {1'b0, s1_ar_ff};
            c_im = clamp33((DATA_W+1)'(0) - {s1_ai_ff[DATA_W-1], s1_ai_ff});
         end
         OP_EQUAL: begin
            s2_eq_in = (s1_ar_ff == s1_br_ff) && (s1_ai_ff == s1_bi_ff);
         end
         default: begin
         end
      endcase
      s2_re_in  = c_re[DATA_W-1:0];
      s2_im_in  = c_im[DATA_W-1:0];
      s2_sat_in = c_re[DATA_W] | c_im[DATA_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
      if (en) begin
         s2_op_ff   <= s1_op_ff;
         s2_p_ff[0] <= s1_ar_ff * s1_br_ff;
         s2_p_ff[1] <= s1_ai_ff * s1_bi_ff;
         s2_p_ff[2] <= s1_ar_ff * s1_bi_ff;
         s2_p_ff[3] <= s1_ai_ff * s1_br_ff;
         s2_p_ff[4] <= sq_x * sq_x;
         s2_p_ff[5] <= sq_y * sq_y;
         s2_re_ff   <= s2_re_in;
         s2_im_ff   <= s2_im_in;
         s2_eq_ff   <= s2_eq_in;
         s2_sat_ff  <= s2_sat_in;
      end
   end

   // ---------------- stage 3: exact sums
   logic               s3_vld_ff;
   op_type             s3_op_ff;
   logic [SUM_W-1:0]   s3_sre_ff, s3_sim_ff, s3_sre_in, s3_sim_in;
   logic [PROD_W-1:0]  s3_sq_ff;
   logic [DATA_W-1:0]  s3_re_ff, s3_im_ff;
   logic               s3_eq_ff, s3_sat_ff;
   logic [SUM_W-1:0]   px [0:3];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         px[k] = {s2_p_ff[k][PROD_W-1], s2_p_ff[k]};
      end
      if (s2_op_ff == OP_DIV) begin
         s3_sre_in = px[0] + px[1];
         s3_sim_in = px[3] - px[2];
      end else begin
         s3_sre_in = px[0] - px[1];
         s3_sim_in = px[2] + px[3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= s2_vld_ff;
      end
      if (en) begin
         s3_op_ff  <= s2_op_ff;
         s3_sre_ff <= s3_sre_in;
         s3_sim_ff <= s3_sim_in;
         // both squares are non-negative and their sum fits 64 bits unsigned
         s3_sq_ff  <= s2_p_ff[4] + s2_p_ff[5];
         s3_re_ff  <= s2_re_ff;
         s3_im_ff  <= s2_im_ff;
         s3_eq_ff  <= s2_eq_ff;
         s3_sat_ff <= s2_sat_ff;
      end
   end

   // ---------------- stage 4: multiply rounding, divide and root setup
   it_type             it_ff  [0:QUOT_W];
   logic [QUOT_W:0]    it_vld_ff;
   it_type             it0_in;
   logic [SUM_W-1:0]   sh_re, sh_im;
   logic [DATA_W:0]    m_re, m_im;
   logic [PROD_W-1:0]  mag_re, mag_im;
   logic [NUM_W-1:0]   num_re, num_im;
   logic [PROD_W-1:0]  hi_re, hi_im;

   always_comb begin
      sh_re  = $unsigned($signed(s3_sre_ff) >>> FRAC_BITS);
      sh_im  = $unsigned($signed(s3_sim_ff) >>> FRAC_BITS);
      m_re   = clamp_wide(sh_re);
      m_im   = clamp_wide(sh_im);
      mag_re = s3_sre_ff[SUM_W-1] ? PROD_W'(-s3_sre_ff) : s3_sre_ff[PROD_W-1:0];
      mag_im = s3_sim_ff[SUM_W-1] ? PROD_W'(-s3_sim_ff) : s3_sim_ff[PROD_W-1:0];
      num_re = {mag_re, {FRAC_BITS{1'b0}}};
      num_im = {mag_im, {FRAC_BITS{1'b0}}};
      hi_re  = PROD_W'(num_re[NUM_W-1:QUOT_W]);
      hi_im  = PROD_W'(num_im[NUM_W-1:QUOT_W]);

      it0_in.op      = s3_op_ff;
      it0_in.neg_re  = s3_sre_ff[SUM_W-1];
      it0_in.neg_im  = s3_sim_ff[SUM_W-1];
      // quotient would need more than QUOT_W bits
      it0_in.ovf_re  = hi_re >= s3_sq_ff;
      it0_in.ovf_im  = hi_im >= s3_sq_ff;
      it0_in.dz      = s3_sq_ff == '0;
      it0_in.den     = s3_sq_ff;
      it0_in.rem_re  = hi_re;
      it0_in.rem_im  = hi_im;
      it0_in.lo_re   = num_re[QUOT_W-1:0];
      it0_in.lo_im   = num_im[QUOT_W-1:0];
      it0_in.q_re    = '0;
      it0_in.q_im    = '0;
      it0_in.sq_n    = s3_sq_ff;
      it0_in.sq_rem  = '0;
      it0_in.sq_root = '0;
      if (s3_op_ff == OP_MUL) begin
         it0_in.early_re  = m_re[DATA_W-1:0];
         it0_in.early_im  = m_im[DATA_W-1:0];
         it0_in.early_sat = m_re[DATA_W] | m_im[DATA_W];
      end else begin
         it0_in.early_re  = s3_re_ff;
         it0_in.early_im  = s3_im_ff;
         it0_in.early_sat = s3_sat_ff;
      end
      it0_in.early_eq = s3_eq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         it_vld_ff[0] <= 1'b0;
      end else if (en) begin
         it_vld_ff[0] <= s3_vld_ff;
      end
      if (en) begin
         it_ff[0] <= it0_in;
      end
   end

   // ---------------- stages 5..: one quotient bit per lane, one root bit in each of the first ROOT_W
   for (genvar g = 1; g <= QUOT_W; g++) begin : g_iter
      it_type            nx;
      logic [PROD_W:0]   r_re, r_im;
      logic              qb_re, qb_im;
      logic [SQREM_W-1:0] sr, st;

      always_comb begin
         nx   = it_ff[g-1];
         r_re = {it_ff[g-1].rem_re, it_ff[g-1].lo_re[QUOT_W-1]};
         r_im = {it_ff[g-1].rem_im, it_ff[g-1].lo_im[QUOT_W-1]};
         qb_re = r_re >= {1'b0, it_ff[g-1].den};
         qb_im = r_im >= {1'b0, it_ff[g-1].den};
         nx.rem_re = qb_re ? PROD_W'(r_re - {1'b0, it_ff[g-1].den}) : r_re[PROD_W-1:0];
         nx.rem_im = qb_im ? PROD_W'(r_im - {1'b0, it_ff[g-1].den}) : r_im[PROD_W-1:0];
         nx.lo_re  = it_ff[g-1].lo_re << 1;
         nx.lo_im  = it_ff[g-1].lo_im << 1;
         nx.q_re   = {it_ff[g-1].q_re[QUOT_W-2:0], qb_re};
         nx.q_im   = {it_ff[g-1].q_im[QUOT_W-2:0], qb_im};
         sr = {it_ff[g-1].sq_rem[SQREM_W-3:0], it_ff[g-1].sq_n[PROD_W-1:PROD_W-2]};
         st = {2'b00, it_ff[g-1].sq_root, 2'b01};
         if (g <= ROOT_W) begin
            nx.sq_n = it_ff[g-1].sq_n << 2;
            if (sr >= st) begin
               nx.sq_rem  = sr - st;
               nx.sq_root = {it_ff[g-1].sq_root[ROOT_W-2:0], 1'b1};
            end else begin
               nx.sq_rem  = sr;
               nx.sq_root = {it_ff[g-1].sq_root[ROOT_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            it_vld_ff[g] <= 1'b0;
         end else if (en) begin
            it_vld_ff[g] <= it_vld_ff[g-1];
         end
         if (en) begin
            it_ff[g] <= nx;
         end
      end
   end

   // ---------------- output register
   it_type             last;
   logic               rsp_vld_ff;
   logic [DATA_W-1:0]  out_re_ff, out_im_ff, out_re_in, out_im_in;
   logic               out_eq_ff, out_sat_ff, out_dz_ff, out_eq_in, out_sat_in, out_dz_in;
   logic [DATA_W:0]    d_re, d_im;

   always_comb begin
      last       = it_ff[QUOT_W];
      d_re       = clamp_sm(last.neg_re, last.ovf_re, last.q_re);
      d_im       = clamp_sm(last.neg_im, last.ovf_im, last.q_im);
      out_re_in  = '0;
      out_im_in  = '0;
      out_eq_in  = 1'b0;
      out_sat_in = 1'b0;
      out_dz_in  = 1'b0;
      case (last.op)
         OP_ADD, OP_SUB, OP_MUL, OP_CONJ, OP_EQUAL: begin
            out_re_in  = last.early_re;
            out_im_in  = last.early_im;
            out_eq_in  = last.early_eq;
            out_sat_in = last.early_sat;
         end
         OP_DIV: begin
            if (last.dz) begin
               out_dz_in = 1'b1;
            end else begin
               out_re_in  = d_re[DATA_W-1:0];
               out_im_in  = d_im[DATA_W-1:0];
               out_sat_in = d_re[DATA_W] | d_im[DATA_W];
            end
         end
         OP_MAG: begin
            out_sat_in = last.sq_root[ROOT_W-1];
            out_re_in  = last.sq_root[ROOT_W-1] ? MAX_POS : last.sq_root[DATA_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= it_vld_ff[QUOT_W];
      end
      if (en) begin
         out_re_ff  <= out_re_in;
         out_im_ff  <= out_im_in;
         out_eq_ff  <= out_eq_in;
         out_sat_ff <= out_sat_in;
         out_dz_ff  <= out_dz_in;
      end
   end

   // whole pipeline moves unless a result is held at the output
   assign en         = !rsp_vld_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {out_im_ff, out_re_ff};
   assign rsp_tuser  = {out_dz_ff, out_sat_ff, out_eq_ff};

endmodule
`default_nettype wire

// ===== design/cau_port_checker.sv =====
// Port-level checks for the complex arithmetic unit, bound to the top level.
// Depends on cau_pkg and complex_arithmetic_unit.
`default_nettype none
module cau_port_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            req_tready,
   input wire                            rsp_tvalid,
   input wire                            rsp_tready,
   input wire [cau_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire [cau_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import cau_pkg::*;

   // held result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // input side only backs up while a result waits
   a_ready: assert property (@(posedge clock) !rsp_tvalid |-> req_tready)
      else $error("input not ready with empty output");

   // equal and divide-by-zero results carry zero data
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[FLAG_EQUAL] || rsp_tuser[FLAG_DZ]) |-> rsp_tdata == '0)
      else $error("flagged result with nonzero data");

   // at most one flag per result
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $countones(rsp_tuser) <= 1)
      else $error("conflicting result flags");

   // first cycle out of reset shows no result
   a_reset: assert property (@(posedge clock) $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind complex_arithmetic_unit cau_port_checker u_cau_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

// ===== test/tb_complex_arithmetic_unit.sv =====
// Testbench for complex_arithmetic_unit: directed corners, random items and a long output stall.
// Results are checked in order against an in-bench predictor; depends on cau_pkg and the RTL.
`default_nettype none
module tb_complex_arithmetic_unit;
   import cau_pkg::*;

   typedef struct {
      logic [DATA_W-1:0] re;
      logic [DATA_W-1:0] im;
      logic              eq;
      logic              sat;
      logic              dz;
   } cplx_result_type;

   localparam int HOLD_CYCLES = 200;   // long output stall, well past the pipeline depth
   localparam int DRAIN_CYCLES = 60;   // pipeline is 38 deep
   localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;   // code with no operation

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;   // a_re, a_im, b_re, b_im
   logic [OP_W-1:0]         req_tuser = '0;   // operation
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;        // result_re, result_im
   logic [RSP_USER_W-1:0]   rsp_tuser;        // is_equal, saturated, divide_by_zero

   cplx_result_type pending_results[$];
   bit           failed = 1'b0;
   bit           hold_output = 1'b0;   // request for one long output stall
   bit           busy_sender = 1'b0;   // no idle gaps on either side while set, unless a long output stall is requested

   complex_arithmetic_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Clamp an exact value to signed 32 bits, flagging when clipped.
   function automatic logic [DATA_W-1:0] clamp32(input logic signed [127:0] v, inout bit sat);
      if (v > 128'sh7FFF_FFFF) begin
         sat = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if (v < -128'sh8000_0000) begin
         sat = 1'b1;
         return 32'h8000_0000;
      end
      return v[DATA_W-1:0];
   endfunction

   // Floor square root, one bit per pass from the top.
   function automatic logic [63:0] floor_root(input logic [127:0] n);
      logic [127:0] r;
      logic [127:0] t;
      r = '0;
      for (int i = 32; i >= 0; i--) begin
         t = r | (128'd1 << i);
         if (t * t <= n) r = t;
      end
      return r[63:0];
   endfunction

   function automatic cplx_result_type predict_cplx(input logic [OP_W-1:0] op,
         input logic signed [DATA_W-1:0] ar, input logic signed [DATA_W-1:0] ai,
         input logic signed [DATA_W-1:0] br, input logic signed [DATA_W-1:0] bi);
      cplx_result_type res;
      logic signed [127:0] xr, xi, yr, yi, num_re, num_im, den;
      logic [63:0] root;
      bit sat;
      res = '{default: '0};
      sat = 1'b0;
      xr = ar; xi = ai; yr = br; yi = bi;
      case (op)
         OP_ADD: begin
            res.re = clamp32(xr + yr, sat);
            res.im = clamp32(xi + yi, sat);
         end
         OP_SUB: begin
            res.re = clamp32(xr - yr, sat);
            res.im = clamp32(xi - yi, sat);
         end
         OP_MUL: begin
            // floor shift of the exact products
            res.re = clamp32((xr * yr - xi * yi) >>> FRAC_BITS, sat);
            res.im = clamp32((xr * yi + xi * yr) >>> FRAC_BITS, sat);
         end
         OP_DIV: begin
            den = yr * yr + yi * yi;
            if (den == 0) begin
               res.dz = 1'b1;
            end else begin
               num_re = (xr * yr + xi * yi) * (128'sd1 <<< FRAC_BITS);
               num_im = (xi * yr - xr * yi) * (128'sd1 <<< FRAC_BITS);
               // signed divide truncates toward zero
               res.re = clamp32(num_re / den, sat);
               res.im = clamp32(num_im / den, sat);
            end
         end
         OP_MAG: begin
            root = floor_root(xr * xr + xi * xi);
            res.re = clamp32($signed({64'd0, root}), sat);
         end
         OP_CONJ: begin
            res.re = ar;
            res.im = clamp32(-xi, sat);
         end
         OP_EQUAL: res.eq = (ar == br) && (ai == bi);
         default: ;
      endcase
      res.sat = sat;
      return res;
   endfunction

   // Mostly short gaps, a few long ones.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one item and hold it until accepted, then maybe idle.
   task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] ar,
         input logic [DATA_W-1:0] ai, input logic [DATA_W-1:0] br,
         input logic [DATA_W-1:0] bi);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {bi, br, ai, ar};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_cplx(op, ar, ai, br, bi));
      gap = busy_sender ? 0 : gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Output side: random stalls, free-running stretches and one long hold-off.
   initial begin
      int n;
      @(posedge clock);
      forever begin
         if (hold_output) begin
            rsp_tready <= 1'b0;
            for (n = 0; n < HOLD_CYCLES; n++) @(posedge clock);
            hold_output = 1'b0;
         end else if (busy_sender) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            n = gap_len();
            if (n > 0) begin
               rsp_tready <= 1'b0;
               repeat (n) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   // Result checker
   always @(posedge clock) begin
      cplx_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result re=%h im=%h", rsp_tdata[31:0], rsp_tdata[63:32]);
            failed = 1'b1;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[DATA_W-1:0] !== want.re) begin
               $error("result_re expected %h actual %h", want.re, rsp_tdata[DATA_W-1:0]);
               failed = 1'b1;
            end
            if (rsp_tdata[RSP_DATA_W-1:DATA_W] !== want.im) begin
               $error("result_im expected %h actual %h", want.im,
                      rsp_tdata[RSP_DATA_W-1:DATA_W]);
               failed = 1'b1;
            end
            if (rsp_tuser[FLAG_EQUAL] !== want.eq) begin
               $error("is_equal expected %b actual %b", want.eq, rsp_tuser[FLAG_EQUAL]);
               failed = 1'b1;
            end
            if (rsp_tuser[FLAG_SAT] !== want.sat) begin
               $error("saturated expected %b actual %b", want.sat, rsp_tuser[FLAG_SAT]);
               failed = 1'b1;
            end
            if (rsp_tuser[FLAG_DZ] !== want.dz) begin
               $error("divide_by_zero expected %b actual %b", want.dz, rsp_tuser[FLAG_DZ]);
               failed = 1'b1;
            end
         end
      end
   end

   // Corners: overflow both ways, full-scale products, zero divisor,
   // magnitude past range, negating the most negative value, unused code.
   task automatic test_corners();
      send_item(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
      send_item(OP_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'h0000_0000);
      send_item(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
      send_item(OP_SUB, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000);
      send_item(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_item(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_item(OP_MUL, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000);
      send_item(OP_MUL, 32'h0002_0000, 32'h0001_0000, 32'h0003_0000, 32'hFFFF_0000);
      send_item(OP_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
      send_item(OP_DIV, 32'h0006_0000, 32'h0000_0000, 32'h0002_0000, 32'h0000_0000);
      send_item(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
      send_item(OP_DIV, 32'hFFFF_0000, 32'h0001_0000, 32'h0003_0000, 32'h0001_0000);
      send_item(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_item(OP_MAG, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
      send_item(OP_MAG, 32'h0003_0000, 32'h0004_0000, 32'h1234_5678, 32'h0000_0000);
      send_item(OP_MAG, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_item(OP_CONJ, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
      send_item(OP_CONJ, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_EQUAL, 32'h1234_5678, 32'h8765_4321, 32'h1234_5678, 32'h8765_4321);
      send_item(OP_EQUAL, 32'h1234_5678, 32'h8765_4321, 32'h1234_5678, 32'h8765_4320);
      send_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   function automatic logic [DATA_W-1:0] rand_part();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return $urandom();
      if (r < 8) return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;   // near zero, within +/-16
      if (r == 8) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      return '0;
   endfunction

   task automatic send_random(input int count);
      logic [OP_W-1:0] op;
      logic [DATA_W-1:0] ar, ai, br, bi;
      for (int i = 0; i < count; i++) begin
         op = ($urandom_range(0, 49) == 0) ? OP_UNUSED : OP_W'($urandom_range(0, 6));
         ar = rand_part(); ai = rand_part(); br = rand_part(); bi = rand_part();
         if ($urandom_range(0, 3) == 0) bi = '0;        // real operand
         if (op == OP_EQUAL && $urandom_range(0, 1)) begin
            br = ar;
            bi = ai;
         end
         if (op == OP_DIV && $urandom_range(0, 9) == 0) begin
            br = '0;
            bi = '0;
         end
         send_item(op, ar, ai, br, bi);
      end
   endtask

   task automatic test_random_mix();
      send_random(450);
      busy_sender = 1'b1;   // back-to-back stretch
      send_random(150);
      busy_sender = 1'b0;
      send_random(300);
   endtask

   // Output held off while the input keeps offering; the pipeline fills and stalls req_.
   task automatic test_output_stall();
      hold_output = 1'b1;
      busy_sender = 1'b1;
      send_random(100);
      busy_sender = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corners();
      test_random_mix();
      test_output_stall();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
design/cau_pkg.sv
design/complex_arithmetic_unit.sv
design/cau_port_checker.sv
test/tb_complex_arithmetic_unit.sv
